// File: hdl/smm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants for the slot and bank memory mapper
// Request and result words, target codes, mapper modes, port numbers and
// configuration register indexes.
// ----------------------------------------------------------------------------
package smm_pkg;

    // Default width of a bank number
    localparam int BANK_BITS_DEF = 8;

    // Request types
    localparam logic [1:0] REQ_MEM_RD  = 2'd0;
    localparam logic [1:0] REQ_MEM_WR  = 2'd1;
    localparam logic [1:0] REQ_PORT_RD = 2'd2;
    localparam logic [1:0] REQ_PORT_WR = 2'd3;

    // Targets
    localparam logic [3:0] TGT_BIOS     = 4'd0;
    localparam logic [3:0] TGT_BASIC    = 4'd1;
    localparam logic [3:0] TGT_CART1    = 4'd2;
    localparam logic [3:0] TGT_CART2    = 4'd3;
    localparam logic [3:0] TGT_RAM      = 4'd4;
    localparam logic [3:0] TGT_UNMAPPED = 4'd5;
    localparam logic [3:0] TGT_SNDWIN   = 4'd6;
    localparam logic [3:0] TGT_SNDREG   = 4'd7;
    localparam logic [3:0] TGT_PORT     = 4'd8;

    // Cartridge mapper modes (anything above MODE_ALT is unmapped)
    localparam logic [2:0] MODE_FLAT   = 3'd0;
    localparam logic [2:0] MODE_BANKED = 3'd1;
    localparam logic [2:0] MODE_SOUND  = 3'd2;
    localparam logic [2:0] MODE_ALT    = 3'd3;

    // Slot codes from the slot select byte
    localparam logic [1:0] SLOT_ROM   = 2'd0;
    localparam logic [1:0] SLOT_CART1 = 2'd1;
    localparam logic [1:0] SLOT_CART2 = 2'd2;
    localparam logic [1:0] SLOT_RAM   = 2'd3;

    // I/O ports
    localparam logic [7:0] PORT_VDP_DATA = 8'h98;
    localparam logic [7:0] PORT_VDP_CTRL = 8'h99;
    localparam logic [7:0] PORT_PSG_ADDR = 8'hA0;
    localparam logic [7:0] PORT_PSG_WDAT = 8'hA1;
    localparam logic [7:0] PORT_PSG_RDAT = 8'hA2;
    localparam logic [7:0] PORT_SLOT     = 8'hA8;
    localparam logic [7:0] PORT_KBD_IN   = 8'hA9;
    localparam logic [7:0] PORT_KBD_SEL  = 8'hAA;

    // Value written to the bank 2 register that opens the sound window
    localparam logic [7:0] SND_ENABLE_VAL = 8'h3F;

    // Configuration register indexes
    localparam logic [2:0] CFG_CART1_MODE = 3'd0;
    localparam logic [2:0] CFG_CART2_MODE = 3'd1;
    localparam logic [2:0] CFG_CART1_MASK = 3'd2;
    localparam logic [2:0] CFG_CART2_BNKA = 3'd3;
    localparam logic [2:0] CFG_CART2_BNKB = 3'd4;
    localparam logic [2:0] CFG_CART2_BNKC = 3'd5;
    localparam logic [2:0] CFG_CART2_BNKD = 3'd6;
    localparam logic [2:0] CFG_CART2_SND  = 3'd7;

    // Request word
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] address;
        logic [7:0]  wdata;
    } req_t;

    // Result word
    typedef struct packed {
        logic [3:0]  target;
        logic [20:0] phys_offset;
        logic        writable;
        logic [7:0]  port_data;
        logic        forward_port;
    } rsp_t;

    // Memory write seen by the cartridge 1 register file
    typedef struct packed {
        logic        en;
        logic [15:0] address;
        logic [7:0]  wdata;
    } c1_wr_t;

endpackage
`default_nettype wire

// File: hdl/smm_cart_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smm_cart_map: cartridge address translation
// Turns a CPU address into a target and offset for one cartridge, following
// its mapper mode, bank registers and sound window enable.
// ----------------------------------------------------------------------------
module smm_cart_map #(
    parameter int BANK_BITS = smm_pkg::BANK_BITS_DEF
) (
    input  wire logic [2:0]                 mode,
    input  wire logic [3:0][BANK_BITS-1:0]  banks,
    input  wire logic                       snd_on,
    input  wire logic [15:0]                address,
    input  wire logic [3:0]                 cart_tgt,
    output logic      [3:0]                 target,
    output logic      [20:0]                phys_offset
);

    logic [1:0] page;
    logic       upper;
    logic       snd_hit;

    assign page    = address[15:14];
    assign upper   = address[13];
    // 0x1800-0x1FFF of the lower half of page 2
    assign snd_hit = (mode == smm_pkg::MODE_SOUND) && (page == 2'd2) && snd_on
                     && (address[12:11] == 2'b11);

    // Mode and page decode
    always_comb
    begin
        target      = cart_tgt;
        phys_offset = 21'(address);
        if (mode == smm_pkg::MODE_FLAT)
        begin
            phys_offset = 21'(address);
        end
        else if (mode > smm_pkg::MODE_ALT)
        begin
            target      = smm_pkg::TGT_UNMAPPED;
            phys_offset = '0;
        end
        else if (!page[0])
        begin
            // pages 0 and 2
            if (upper)
                phys_offset = 21'({banks[3], address[12:0]});
            else if (snd_hit)
            begin
                target      = smm_pkg::TGT_SNDWIN;
                phys_offset = 21'(address[9:0]);
            end
            else
                phys_offset = 21'({banks[2], address[12:0]});
        end
        else
        begin
            // pages 1 and 3
            if (upper)
                phys_offset = 21'({banks[1], address[12:0]});
            else if (mode == smm_pkg::MODE_BANKED)
                phys_offset = 21'(address[12:0]);
            else
                phys_offset = 21'({banks[0], address[12:0]});
        end
    end

endmodule
`default_nettype wire

// File: hdl/smm_cart1_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smm_cart1_regs: cartridge 1 bank registers
// Decodes memory writes into the cartridge 1 register ranges and holds the
// four bank numbers and the sound window enable.
// ----------------------------------------------------------------------------
module smm_cart1_regs #(
    parameter int BANK_BITS = smm_pkg::BANK_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire smm_pkg::c1_wr_t            wr,
    input  wire logic                       here,
    input  wire logic [2:0]                 mode,
    input  wire logic [7:0]                 bank_mask,
    output logic      [3:0][BANK_BITS-1:0]  banks,
    output logic                            snd_on
);

    logic [3:0][BANK_BITS-1:0] banks_reg, banks_next;
    logic                      snd_reg, snd_next;
    logic [7:0]                masked;
    logic [BANK_BITS-1:0]      m;
    logic [4:0]                blk2k;   // 2 KB block number
    logic [2:0]                blk8k;   // 8 KB block number

    assign masked = wr.wdata & bank_mask;
    assign m      = masked[BANK_BITS-1:0];
    assign blk2k  = wr.address[15:11];
    assign blk8k  = wr.address[15:13];

    // Register range decode
    always_comb
    begin
        banks_next = banks_reg;
        snd_next   = snd_reg;
        if (wr.en && here)
        begin
            unique case (mode)
                smm_pkg::MODE_BANKED:
                begin
                    if (blk8k == 3'd3)
                        banks_next[1] = m;
                    else if (blk8k == 3'd4)
                        banks_next[2] = m;
                    else if (blk8k == 3'd5)
                        banks_next[3] = m;
                end
                smm_pkg::MODE_SOUND:
                begin
                    if (blk2k == 5'h0A)         // 0x5000
                        banks_next[0] = m;
                    else if (blk2k == 5'h0E)    // 0x7000
                        banks_next[1] = m;
                    else if (blk2k == 5'h12)    // 0x9000
                    begin
                        banks_next[2] = m;
                        snd_next      = (wr.wdata == smm_pkg::SND_ENABLE_VAL);
                    end
                    else if (blk2k == 5'h16)    // 0xB000
                        banks_next[3] = m;
                end
                smm_pkg::MODE_ALT:
                begin
                    // 0x6000-0x7FFF, one bank per 2 KB block
                    if (blk8k == 3'd3)
                        banks_next[wr.address[12:11]] = m;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            banks_reg <= '0;
            snd_reg   <= 1'b0;
        end
        else
        begin
            banks_reg <= banks_next;
            snd_reg   <= snd_next;
        end
    end

    assign banks  = banks_reg;
    assign snd_on = snd_reg;

endmodule
`default_nettype wire

// File: hdl/slot_and_bank_memory_mapper_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slot_and_bank_memory_mapper_top: slot and bank memory mapper
// Translates CPU memory and port accesses through the slot select byte and
// the cartridge bank mappers.
// ----------------------------------------------------------------------------
// One request word is taken per clock while busy is low; busy is high only in
// reset and the first cycle after it. The result word is loaded at the first
// clock edge after the request is taken and is held for exactly one cycle with
// done high; it cannot be stalled. The block is one registered translation
// stage between a request register and a result register, so it sustains one
// access per clock; the slot byte and cartridge 1 bank registers are updated
// at the same edge that loads the result, so each access sees the effect of
// the one before it. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module slot_and_bank_memory_mapper_top #(
    parameter int BANK_BITS = smm_pkg::BANK_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire smm_pkg::req_t request,
    output logic               done,
    output smm_pkg::rsp_t      result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [7:0]    cfg_data
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [2:0]                cart1_mode_reg;
    logic [2:0]                cart2_mode_reg;
    logic [7:0]                cart1_mask_reg;
    logic [3:0][BANK_BITS-1:0] cart2_banks_reg;
    logic                      cart2_snd_reg;
    logic                      cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart1_mode_reg  <= smm_pkg::MODE_FLAT;
            cart2_mode_reg  <= smm_pkg::MODE_FLAT;
            cart1_mask_reg  <= 8'hFF;
            cart2_banks_reg <= '0;
            cart2_snd_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                smm_pkg::CFG_CART1_MODE: cart1_mode_reg     <= cfg_data[2:0];
                smm_pkg::CFG_CART2_MODE: cart2_mode_reg     <= cfg_data[2:0];
                smm_pkg::CFG_CART1_MASK: cart1_mask_reg     <= cfg_data;
                smm_pkg::CFG_CART2_BNKA: cart2_banks_reg[0] <= cfg_data[BANK_BITS-1:0];
                smm_pkg::CFG_CART2_BNKB: cart2_banks_reg[1] <= cfg_data[BANK_BITS-1:0];
                smm_pkg::CFG_CART2_BNKC: cart2_banks_reg[2] <= cfg_data[BANK_BITS-1:0];
                smm_pkg::CFG_CART2_BNKD: cart2_banks_reg[3] <= cfg_data[BANK_BITS-1:0];
                smm_pkg::CFG_CART2_SND:  cart2_snd_reg      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Request register
    // ------------------------------------------------------------------------
    logic          busy_reg;
    logic          req_valid_reg;
    smm_pkg::req_t req_reg;
    logic          accept;

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= 1'b0;
            req_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= request;
    end

    // ------------------------------------------------------------------------
    // Slot decode
    // ------------------------------------------------------------------------
    logic [7:0] slot_select_reg, slot_select_next;
    logic [1:0] page;
    logic [1:0] slot;
    logic       is_mem;
    logic       is_mem_wr;
    logic [7:0] port;

    assign page      = req_reg.address[15:14];
    assign slot      = 2'(slot_select_reg >> {page, 1'b0});
    assign is_mem    = !req_reg.req_type[1];
    assign is_mem_wr = req_valid_reg && (req_reg.req_type == smm_pkg::REQ_MEM_WR);
    assign port      = req_reg.address[7:0];

    // ------------------------------------------------------------------------
    // Cartridge translation and cartridge 1 registers
    // ------------------------------------------------------------------------
    logic [3:0][BANK_BITS-1:0] cart1_banks;
    logic                      cart1_snd;
    logic [3:0]                c1_tgt, c2_tgt;
    logic [20:0]               c1_off, c2_off;
    smm_pkg::c1_wr_t           c1_wr;

    assign c1_wr.en      = is_mem_wr;
    assign c1_wr.address = req_reg.address;
    assign c1_wr.wdata   = req_reg.wdata;

    smm_cart1_regs #(
        .BANK_BITS (BANK_BITS)
    ) u_cart1_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (c1_wr),
        .here      (slot == smm_pkg::SLOT_CART1),
        .mode      (cart1_mode_reg),
        .bank_mask (cart1_mask_reg),
        .banks     (cart1_banks),
        .snd_on    (cart1_snd)
    );

    smm_cart_map #(
        .BANK_BITS (BANK_BITS)
    ) u_cart1_map (
        .mode        (cart1_mode_reg),
        .banks       (cart1_banks),
        .snd_on      (cart1_snd),
        .address     (req_reg.address),
        .cart_tgt    (smm_pkg::TGT_CART1),
        .target      (c1_tgt),
        .phys_offset (c1_off)
    );

    smm_cart_map #(
        .BANK_BITS (BANK_BITS)
    ) u_cart2_map (
        .mode        (cart2_mode_reg),
        .banks       (cart2_banks_reg),
        .snd_on      (cart2_snd_reg),
        .address     (req_reg.address),
        .cart_tgt    (smm_pkg::TGT_CART2),
        .target      (c2_tgt),
        .phys_offset (c2_off)
    );

    // ------------------------------------------------------------------------
    // Result assembly
    // ------------------------------------------------------------------------
    smm_pkg::rsp_t rsp_next;
    smm_pkg::rsp_t rsp_reg;
    logic          done_reg;
    logic          snd_reg_wr;

    // write into the cartridge 1 sound chip window at 0x9800-0x9FFF
    assign snd_reg_wr = (req_reg.req_type == smm_pkg::REQ_MEM_WR)
                        && (cart1_mode_reg == smm_pkg::MODE_SOUND)
                        && (slot == smm_pkg::SLOT_CART1) && cart1_snd
                        && (req_reg.address[15:11] == 5'h13);

    always_comb
    begin
        rsp_next              = '0;
        rsp_next.target       = smm_pkg::TGT_PORT;
        rsp_next.port_data    = 8'hFF;
        slot_select_next      = slot_select_reg;
        if (is_mem)
        begin
            unique case (slot)
                smm_pkg::SLOT_ROM:
                begin
                    if (page == 2'd0)
                    begin
                        rsp_next.target      = smm_pkg::TGT_BIOS;
                        rsp_next.phys_offset = 21'(req_reg.address[13:0]);
                    end
                    else if (page == 2'd1)
                    begin
                        rsp_next.target      = smm_pkg::TGT_BASIC;
                        rsp_next.phys_offset = 21'(req_reg.address[13:0]);
                    end
                    else
                        rsp_next.target      = smm_pkg::TGT_UNMAPPED;
                end
                smm_pkg::SLOT_CART1:
                begin
                    rsp_next.target      = c1_tgt;
                    rsp_next.phys_offset = c1_off;
                end
                smm_pkg::SLOT_CART2:
                begin
                    rsp_next.target      = c2_tgt;
                    rsp_next.phys_offset = c2_off;
                end
                smm_pkg::SLOT_RAM:
                begin
                    rsp_next.target      = smm_pkg::TGT_RAM;
                    rsp_next.phys_offset = 21'(req_reg.address);
                    rsp_next.writable    = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (snd_reg_wr)
            begin
                rsp_next.target      = smm_pkg::TGT_SNDREG;
                rsp_next.phys_offset = 21'(req_reg.address[7:0]);
                rsp_next.writable    = 1'b0;
            end
        end
        else if (req_reg.req_type == smm_pkg::REQ_PORT_RD)
        begin
            if (port == smm_pkg::PORT_SLOT)
                rsp_next.port_data = slot_select_reg;
            else
                rsp_next.forward_port = (port == smm_pkg::PORT_VDP_DATA)
                                     || (port == smm_pkg::PORT_VDP_CTRL)
                                     || (port == smm_pkg::PORT_PSG_RDAT)
                                     || (port == smm_pkg::PORT_KBD_IN)
                                     || (port == smm_pkg::PORT_KBD_SEL);
        end
        else
        begin
            if (port == smm_pkg::PORT_SLOT)
            begin
                if (req_valid_reg)
                    slot_select_next = req_reg.wdata;
            end
            else
                rsp_next.forward_port = (port == smm_pkg::PORT_VDP_DATA)
                                     || (port == smm_pkg::PORT_VDP_CTRL)
                                     || (port == smm_pkg::PORT_PSG_ADDR)
                                     || (port == smm_pkg::PORT_PSG_WDAT)
                                     || (port == smm_pkg::PORT_KBD_SEL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_select_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            slot_select_reg <= slot_select_next;
            done_reg        <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
            rsp_reg <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // every taken request is followed by a result with done high
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("taken request produced no result");

    // no result without an earlier taken request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without a request");

    // only RAM is writable
    a_wr_ram: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.writable) |-> (result.target == smm_pkg::TGT_RAM))
        else $error("writable result outside RAM");

    // the slot byte moves only on a port write to the slot port
    a_slot_upd: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(slot_select_reg) |->
            $past(req_valid_reg && (req_reg.req_type == smm_pkg::REQ_PORT_WR)
                  && (req_reg.address[7:0] == smm_pkg::PORT_SLOT)))
        else $error("slot select changed without a slot port write");

endmodule
`default_nettype wire
